>>> rtl/core/adsr_pkg.sv
// Shared types and constants of the ADSR envelope generator.
package adsr_pkg;

  // Register field widths
  localparam int CntW      = 24;
  localparam int SusW      = 16;
  localparam int CfgDataW  = 24;
  localparam int CfgIdxW   = 2;
  localparam int ActW      = 2;
  localparam int TimeInW   = 32;
  localparam int LevelOutW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxAttack  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxDecay   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxSustain = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxRelease = 2'd3;

  // Register reset values
  localparam logic [CntW-1:0] AttackRst  = 24'd480;
  localparam logic [CntW-1:0] DecayRst   = 24'd4800;
  localparam logic [SusW-1:0] SustainRst = 16'd49152;
  localparam logic [CntW-1:0] ReleaseRst = 24'd9600;

  // Action codes; any other code is a plain sample
  localparam logic [ActW-1:0] ActKeyOn  = 2'd1;
  localparam logic [ActW-1:0] ActKeyOff = 2'd2;

  typedef struct packed {
    logic [CntW-1:0] attack;
    logic [CntW-1:0] decay;
    logic [SusW-1:0] sustain;
    logic [CntW-1:0] release_t;
  } cfg_t;

endpackage

>>> rtl/core/adsr_cfg.sv
// Configuration registers of the ADSR envelope generator.
module adsr_cfg import adsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack    <= AttackRst;
      cfg_q.decay     <= DecayRst;
      cfg_q.sustain   <= SustainRst;
      cfg_q.release_t <= ReleaseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxAttack:  cfg_q.attack    <= cfg_data_i;
        CfgIdxDecay:   cfg_q.decay     <= cfg_data_i;
        CfgIdxSustain: cfg_q.sustain   <= cfg_data_i[SusW-1:0];
        CfgIdxRelease: cfg_q.release_t <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/adsr_muldiv.sv
// Bit-serial multiply then restoring divide: q = x * y / d, with x <= d.
module adsr_muldiv import adsr_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [CntW-1:0]       x_i,
  input  logic [LEVEL_BITS-1:0] y_i,
  input  logic [CntW-1:0]       d_i,
  output logic                  done_o,
  output logic [LEVEL_BITS-1:0] q_o
);

  localparam int PW       = CntW + LEVEL_BITS;
  localparam int MaxSteps = (CntW > LEVEL_BITS) ? CntW : LEVEL_BITS;
  localparam int CW       = $clog2(MaxSteps);

  typedef enum logic [1:0] {MdIdle, MdMul, MdDiv} md_state_e;

  md_state_e             state_q;
  logic [CW-1:0]         cnt_q;
  logic                  done_q;
  logic [PW-1:0]         prod_q;
  logic [LEVEL_BITS-1:0] y_q;
  logic [CntW-1:0]       d_q;

  logic [LEVEL_BITS:0]   sum;
  logic [CntW:0]         trial;
  logic                  ge;
  logic [CntW:0]         rem;

  // Multiply step: LSB first, add y into the high part and shift right.
  // Divide step: bring down one dividend bit, subtract d when it fits.
  always_comb begin
    sum   = {1'b0, prod_q[PW-1:CntW]} + (prod_q[0] ? {1'b0, y_q} : '0);
    trial = {prod_q[PW-1:LEVEL_BITS], prod_q[LEVEL_BITS-1]};
    ge    = trial >= {1'b0, d_q};
    rem   = ge ? (trial - {1'b0, d_q}) : trial;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MdIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MdIdle: begin
          if (start_i) begin
            cnt_q   <= '0;
            state_q <= MdMul;
          end
        end
        MdMul: begin
          if (cnt_q == CW'(CntW - 1)) begin
            cnt_q   <= '0;
            state_q <= MdDiv;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        MdDiv: begin
          if (cnt_q == CW'(LEVEL_BITS - 1)) begin
            done_q  <= 1'b1;
            state_q <= MdIdle;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= MdIdle;
      endcase
    end
  end

  // Datapath: product, then remainder and quotient share one register
  always_ff @(posedge clk_i) begin
    case (state_q)
      MdIdle: begin
        if (start_i) begin
          prod_q <= {{LEVEL_BITS{1'b0}}, x_i};
          y_q    <= y_i;
          d_q    <= d_i;
        end
      end
      MdMul:   prod_q <= {sum, prod_q[CntW-1:1]};
      MdDiv:   prod_q <= {rem[CntW-1:0], prod_q[LEVEL_BITS-2:0], ge};
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = prod_q[LEVEL_BITS-1:0];

endmodule

>>> rtl/core/adsr_envelope_generator_top.sv
// A ramp request runs the serial unit's 24 multiply and LEVEL_BITS divide steps;
// a request with a flat level skips the serial unit.
// Throughput: one request at a time; the result sits in an output register, so
// the next request is taken while it waits. The serial multiply-divide sets the rate.
// Reset: async active low; envelope idle at level 0, registers at defaults.
module adsr_envelope_generator_top import adsr_pkg::*; #(
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ActW-1:0]      action_i,
  input  logic [TimeInW-1:0]   time_now_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LevelOutW-1:0] level_o,
  output logic                 active_o
);

  localparam int CmpW = (TIME_BITS > CntW) ? TIME_BITS : CntW;
  localparam logic [LEVEL_BITS-1:0] Full = '1;

  typedef enum logic [2:0] {StIdle, StElap, StCmp, StSel, StCalc, StDone} state_e;

  cfg_t                  cfg;
  state_e                state_q;

  logic [ActW-1:0]       act_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [TIME_BITS-1:0]  e_q;
  logic [CmpW-1:0]       ed_q;
  logic                  a_hit_q;
  logic                  r_hit_q;
  logic                  kill_q;
  logic                  sub_q;
  logic [LEVEL_BITS-1:0] base_q;
  logic [LEVEL_BITS-1:0] res_q;

  logic [TIME_BITS-1:0]  seg_begin_q;
  logic [LEVEL_BITS-1:0] att_start_q;
  logic [LEVEL_BITS-1:0] last_q;
  logic                  key_held_q;
  logic                  sounding_q;

  logic                  out_valid_q;
  logic [LevelOutW-1:0]  level_q;
  logic                  active_q;

  logic                  md_start_q;
  logic [CntW-1:0]       md_x_q;
  logic [LEVEL_BITS-1:0] md_y_q;
  logic [CntW-1:0]       md_d_q;
  logic                  md_done;
  logic [LEVEL_BITS-1:0] md_q;

  logic                  in_accept;
  logic                  out_free;
  logic [CmpW-1:0]       e_w;
  logic [LEVEL_BITS-1:0] sus_cap;
  logic                  key_on;

  adsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  adsr_muldiv #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start_q),
    .x_i     (md_x_q),
    .y_i     (md_y_q),
    .d_i     (md_d_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // Handshake and helpers
  always_comb begin
    in_accept = in_valid_i && (state_q == StIdle);
    out_free  = !out_valid_q || !out_stall_i;
    e_w       = CmpW'(e_q);
    key_on    = (act_q == ActKeyOn);
    if ((LEVEL_BITS < SusW) && ((cfg.sustain >> LEVEL_BITS) != '0)) begin
      sus_cap = Full;
    end else begin
      sus_cap = LEVEL_BITS'(cfg.sustain);
    end
  end

  // Control sequencer, envelope state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seg_begin_q <= '0;
      att_start_q <= '0;
      last_q      <= '0;
      key_held_q  <= 1'b0;
      sounding_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      active_q    <= 1'b0;
      md_start_q  <= 1'b0;
    end else begin
      md_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            // Key off opens the release before evaluation
            if (action_i == ActKeyOff) begin
              seg_begin_q <= TIME_BITS'(time_now_i);
              key_held_q  <= 1'b0;
            end
            state_q <= StElap;
          end
        end
        StElap:  state_q <= StCmp;
        StCmp:   state_q <= StSel;
        StSel: begin
          if (key_held_q) begin
            if (a_hit_q || ((cfg.decay != '0) && (ed_q < CmpW'(cfg.decay)))) begin
              md_start_q <= 1'b1;
              state_q    <= StCalc;
            end else begin
              state_q <= StDone;
            end
          end else if (r_hit_q) begin
            md_start_q <= 1'b1;
            state_q    <= StCalc;
          end else begin
            state_q <= StDone;
          end
        end
        StCalc: begin
          if (md_done) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            level_q     <= LevelOutW'(res_q);
            active_q    <= key_on ? 1'b1 : (kill_q ? 1'b0 : sounding_q);
            if (key_held_q) begin
              last_q <= res_q;
            end else if (kill_q) begin
              last_q     <= '0;
              sounding_q <= 1'b0;
            end
            if (key_on) begin
              att_start_q <= res_q;
              seg_begin_q <= now_q;
              key_held_q  <= 1'b1;
              sounding_q  <= 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Request datapath: elapsed time, segment pick, operands and result
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          act_q <= action_i;
          now_q <= TIME_BITS'(time_now_i);
        end
      end
      StElap: e_q <= now_q - seg_begin_q;
      StCmp: begin
        a_hit_q <= (cfg.attack != '0) && (e_w <= CmpW'(cfg.attack));
        r_hit_q <= (cfg.release_t != '0) && (e_w < CmpW'(cfg.release_t));
        ed_q    <= e_w - CmpW'(cfg.attack);
      end
      StSel: begin
        kill_q <= 1'b0;
        if (key_held_q) begin
          if (a_hit_q) begin
            // Attack: rise from start level toward full scale
            md_x_q <= e_w[CntW-1:0];
            md_y_q <= Full - att_start_q;
            md_d_q <= cfg.attack;
            base_q <= att_start_q;
            sub_q  <= 1'b0;
          end else begin
            // Decay: fall from full scale toward sustain
            md_x_q <= ed_q[CntW-1:0];
            md_y_q <= Full - sus_cap;
            md_d_q <= cfg.decay;
            base_q <= Full;
            sub_q  <= 1'b1;
          end
          res_q <= sus_cap;
        end else begin
          // Release: fall from stored level to zero
          md_x_q <= e_w[CntW-1:0];
          md_y_q <= last_q;
          md_d_q <= cfg.release_t;
          base_q <= last_q;
          sub_q  <= 1'b1;
          res_q  <= '0;
          kill_q <= !r_hit_q;
        end
      end
      StCalc: begin
        if (md_done) begin
          res_q <= sub_q ? (base_q - md_q) : (base_q + md_q);
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign active_o    = active_q;

endmodule

>>> bench/adsr_envelope_generator_top_tb.sv
// Self-checking bench for the ADSR envelope generator: directed and random notes scored against a predictor.
module adsr_envelope_generator_top_tb;
  import adsr_pkg::*;

  localparam logic [ActW-1:0] ActSample = 2'd0;
  localparam logic [ActW-1:0] ActAlt    = 2'd3;   // unused code, acts as a sample
  localparam longint unsigned FullScale = 64'd65535;
  localparam int PhaseItems = 122;
  localparam int SettleCycles = 64;
  localparam int HangLimit = 4000;

  typedef struct packed {
    logic [ActW-1:0]    act;
    logic [TimeInW-1:0] stamp;
  } request_t;

  typedef struct packed {
    logic [LevelOutW-1:0] level;
    logic                 active;
  } envelope_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [ActW-1:0]      action_i = '0;
  logic [TimeInW-1:0]   time_now_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [LevelOutW-1:0] level_o;
  logic                 active_o;

  adsr_envelope_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .time_now_i  (time_now_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .active_o    (active_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Envelope predictor state and register copies
  longint unsigned     atk_len = 480;
  longint unsigned     dec_len = 4800;
  longint unsigned     sus_lvl = 49152;
  longint unsigned     rel_len = 9600;
  logic [TimeInW-1:0]  seg_start = '0;
  logic [LevelOutW-1:0] rise_from = '0;
  logic [LevelOutW-1:0] held_level = '0;
  logic                key_down = 1'b0;
  logic                sounding = 1'b0;

  request_t  pend_q[$];
  envelope_t level_q[$];
  logic [TimeInW-1:0] tnow = '0;
  int queued = 0;
  int errors = 0;
  int src_pct = 0;
  int snk_pct = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int hang_cnt = 0;

  // Level at a time stamp; updates the stored level as the block does
  function automatic logic [LevelOutW-1:0] level_at(input logic [TimeInW-1:0] now);
    logic [TimeInW-1:0] e32;
    longint unsigned el, lv;
    e32 = now - seg_start;
    el = 64'(e32);
    if (key_down) begin
      if (atk_len != 0 && el <= atk_len)
        lv = rise_from + (el * (FullScale - rise_from)) / atk_len;
      else if (dec_len != 0 && el < atk_len + dec_len)
        lv = FullScale - ((el - atk_len) * (FullScale - sus_lvl)) / dec_len;
      else
        lv = sus_lvl;
      held_level = lv[LevelOutW-1:0];
    end else if (rel_len != 0 && el < rel_len) begin
      lv = held_level - (el * held_level) / rel_len;
    end else begin
      sounding = 1'b0;
      held_level = '0;
      lv = 0;
    end
    return lv[LevelOutW-1:0];
  endfunction

  function automatic envelope_t next_envelope(input logic [ActW-1:0] act,
                                              input logic [TimeInW-1:0] now);
    envelope_t res;
    logic [LevelOutW-1:0] lv;
    case (act)
      ActKeyOn: begin
        lv = level_at(now);
        rise_from = lv;
        seg_start = now;
        key_down = 1'b1;
        sounding = 1'b1;
      end
      ActKeyOff: begin
        seg_start = now;
        key_down = 1'b0;
        lv = level_at(now);
      end
      default: lv = level_at(now);
    endcase
    res.level = lv;
    res.active = sounding;
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        level_q = {level_q, next_envelope(action_i, time_now_i)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pend_q.size() != 0) begin
          if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
            src_gap <= $urandom_range(0, 13);
            in_valid_i <= 1'b0;
          end else begin
            in_valid_i <= 1'b1;
            action_i <= pend_q[0].act;
            time_now_i <= pend_q[0].stamp;
            pend_q.pop_front();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (level_q.size() == 0) begin
          $error("result with nothing expected: level %0d active %0d", level_o, active_o);
          errors++;
        end else begin
          if (level_o !== level_q[0].level) begin
            $error("level: expected %0d, got %0d", level_q[0].level, level_o);
            errors++;
          end
          if (active_o !== level_q[0].active) begin
            $error("active: expected %0d, got %0d", level_q[0].active, active_o);
            errors++;
          end
          level_q.pop_front();
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_stall_i <= 1'b1;
      end else if (snk_pct != 0 && $urandom_range(0, 99) < snk_pct) begin
        snk_gap <= $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) hang_cnt <= 0;
      else hang_cnt <= hang_cnt + 1;
      if (hang_cnt >= HangLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [ActW-1:0] act, input logic [TimeInW-1:0] stamp);
    request_t req;
    req.act = act;
    req.stamp = stamp;
    pend_q = {pend_q, req};
    queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || level_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgIdxAttack:  atk_len = 64'(val);
      CfgIdxDecay:   dec_len = 64'(val);
      CfgIdxSustain: sus_lvl = 64'(val[SusW-1:0]);
      CfgIdxRelease: rel_len = 64'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CntW-1:0] a, input logic [CntW-1:0] d,
                          input logic [SusW-1:0] s, input logic [CntW-1:0] r);
    write_reg(CfgIdxAttack, a);
    write_reg(CfgIdxDecay, d);
    write_reg(CfgIdxSustain, CfgDataW'(s));
    write_reg(CfgIdxRelease, r);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [TimeInW-1:0] rand_step(input longint unsigned span);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return $urandom_range(0, span[31:0]);
  endfunction

  function automatic logic [ActW-1:0] pick_sample();
    return ($urandom_range(0, 5) == 0) ? ActAlt : ActSample;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 40;
    endcase
  endfunction

  // One note: attack, decay and sustain samples, maybe a retrigger, then release
  task automatic play_note();
    longint unsigned ad_span, rel_span;
    int n;
    ad_span = (atk_len + dec_len) / 3 + 2;
    rel_span = rel_len / 3 + 2;
    push_item(ActKeyOn, tnow);
    n = $urandom_range(1, 6);
    repeat (n) begin
      tnow += rand_step(ad_span);
      push_item(pick_sample(), tnow);
    end
    if ($urandom_range(0, 3) == 0) begin
      tnow += rand_step(ad_span);
      push_item(ActKeyOn, tnow);
      tnow += rand_step(ad_span);
      push_item(pick_sample(), tnow);
    end
    tnow += rand_step(ad_span);
    push_item(ActKeyOff, tnow);
    n = $urandom_range(1, 5);
    repeat (n) begin
      tnow += rand_step(rel_span);
      push_item(pick_sample(), tnow);
    end
    if ($urandom_range(0, 2) == 0) begin
      tnow += TimeInW'(rel_len) + $urandom_range(0, 50);
      push_item(ActSample, tnow);
    end
  endtask

  // Noise: any action, wild or backward time stamps
  task automatic play_noise();
    case ($urandom_range(0, 3))
      0: tnow = $urandom;
      1: tnow -= $urandom_range(1, 1000);
      default: tnow += $urandom_range(0, 100);
    endcase
    push_item(ActW'($urandom_range(0, 3)), tnow);
  endtask

  initial begin
    int p;
    int start;
    logic [CntW-1:0] a, d, r;
    logic [SusW-1:0] s;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: default registers through a whole note
    src_pct = 20;
    snk_pct = 20;
    push_item(ActSample, 32'd0);          // idle envelope
    push_item(ActKeyOff, 32'd5);          // key off with no note
    push_item(ActKeyOn, 32'd100);
    push_item(ActSample, 32'd100);
    push_item(ActSample, 32'd340);        // mid attack
    push_item(ActSample, 32'd580);        // attack peak
    push_item(ActSample, 32'd2000);       // decay
    push_item(ActSample, 32'd5380);       // decay end
    push_item(ActAlt, 32'd9100);          // sustain, unused code
    push_item(ActKeyOff, 32'd10000);
    push_item(ActSample, 32'd14800);      // mid release
    push_item(ActKeyOn, 32'd16000);       // retrigger from the release level
    push_item(ActSample, 32'd16240);
    push_item(ActKeyOff, 32'd16300);
    push_item(ActSample, 32'd30000);      // release over
    push_item(ActSample, 32'd30001);
    push_item(ActKeyOn, 32'd40000);
    push_item(ActSample, 32'd39000);      // time going backward
    push_item(ActKeyOn, 32'hFFFF_FF00);
    push_item(ActSample, 32'h0000_0050);  // time stamp wraps
    push_item(ActSample, 32'hFFFF_FFFF);
    wait_idle();

    // Directed: zero attack, decay and release times
    set_regs('0, '0, 16'hFFFF, '0);
    push_item(ActKeyOn, 32'd1000);
    push_item(ActSample, 32'd1010);
    push_item(ActKeyOff, 32'd1020);
    push_item(ActSample, 32'd1030);
    tnow = 32'd2000;

    // Random phases, each with its own register setting
    for (p = 0; p < 8; p++) begin
      wait_idle();
      a = CntW'($urandom_range(1, 600));
      d = CntW'($urandom_range(1, 2000));
      s = SusW'($urandom);
      r = CntW'($urandom_range(1, 2000));
      case (p)
        1: a = '0;
        2: d = '0;
        3: r = '0;
        4: begin
          a = '1;
          d = '1;
          s = '1;
          r = '1;
        end
        5: s = '0;
        6: begin
          a = CntW'($urandom);
          d = CntW'($urandom);
          r = CntW'($urandom);
        end
        default: ;
      endcase
      set_regs(a, d, s, r);
      src_pct = (p == 7) ? 0 : pick_pct();
      snk_pct = (p == 7) ? 0 : pick_pct();
      start = queued;
      while (queued - start < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) play_noise();
        else play_note();
      end
    end

    wait_idle();
    if (errors == 0 && level_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
